// File: rtl/keycode_to_vt100_byte_encoder_unit_assert.svh
// Assertion macros for the checker of the key encoder.
`ifndef KEYCODE_TO_VT100_BYTE_ENCODER_UNIT_ASSERT_SVH
`define KEYCODE_TO_VT100_BYTE_ENCODER_UNIT_ASSERT_SVH

// Check a property on every edge outside reset.
`define KVT_CHECK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("kvt assertion failed");

// Check a property on every edge, reset included.
`define KVT_CHECK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("kvt assertion failed");

`endif

// File: rtl/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

  // Command codes
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_LOST = 1'b1;

  // Event type of key events
  localparam logic [4:0] EV_KEY = 5'd1;

  // Key values
  localparam logic [1:0] KV_RELEASE = 2'd0;
  localparam logic [1:0] KV_PRESS   = 2'd1;
  localparam logic [1:0] KV_REPEAT  = 2'd2;

  // Result kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_SETUP = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_DUP_WINDOW = 2'd0;
  localparam logic [1:0] CFG_NEWLINE    = 2'd1;
  localparam logic [1:0] CFG_CURSOR_APP = 2'd2;

  // Configuration reset values
  localparam logic [7:0] DUP_WINDOW_RESET = 8'd30;

  // Owner entry width: zero means no owner, else node + 1
  localparam int OWNER_BITS = 4;

  // Keycodes
  localparam logic [9:0] KC_DIG_FIRST = 10'd2;
  localparam logic [9:0] KC_DIG_LAST  = 10'd11;
  localparam logic [9:0] KC_ENTER     = 10'd28;
  localparam logic [9:0] KC_LCTRL     = 10'd29;
  localparam logic [9:0] KC_LSHIFT    = 10'd42;
  localparam logic [9:0] KC_RSHIFT    = 10'd54;
  localparam logic [9:0] KC_LALT      = 10'd56;
  localparam logic [9:0] KC_TAB_LIMIT = 10'd58;
  localparam logic [9:0] KC_CAPS      = 10'd58;
  localparam logic [9:0] KC_F1        = 10'd59;
  localparam logic [9:0] KC_F2        = 10'd60;
  localparam logic [9:0] KC_F3        = 10'd61;
  localparam logic [9:0] KC_F4        = 10'd62;
  localparam logic [9:0] KC_F5        = 10'd63;
  localparam logic [9:0] KC_F6        = 10'd64;
  localparam logic [9:0] KC_F7        = 10'd65;
  localparam logic [9:0] KC_F8        = 10'd66;
  localparam logic [9:0] KC_F9        = 10'd67;
  localparam logic [9:0] KC_F10       = 10'd68;
  localparam logic [9:0] KC_F11       = 10'd87;
  localparam logic [9:0] KC_F12       = 10'd88;
  localparam logic [9:0] KC_RCTRL     = 10'd97;
  localparam logic [9:0] KC_RALT      = 10'd100;
  localparam logic [9:0] KC_HOME      = 10'd102;
  localparam logic [9:0] KC_UP        = 10'd103;
  localparam logic [9:0] KC_PGUP      = 10'd104;
  localparam logic [9:0] KC_LEFT      = 10'd105;
  localparam logic [9:0] KC_RIGHT     = 10'd106;
  localparam logic [9:0] KC_END       = 10'd107;
  localparam logic [9:0] KC_DOWN      = 10'd108;
  localparam logic [9:0] KC_PGDN      = 10'd109;
  localparam logic [9:0] KC_INSERT    = 10'd110;
  localparam logic [9:0] KC_DELETE    = 10'd111;

  // Characters
  localparam logic [7:0] ASC_NUL     = 8'h00;
  localparam logic [7:0] ASC_LF      = 8'h0a;
  localparam logic [7:0] ASC_CR      = 8'h0d;
  localparam logic [7:0] ASC_ESC     = 8'h1b;
  localparam logic [7:0] ASC_CTRL    = 8'h1f;
  localparam logic [7:0] ASC_CASE    = 8'h20;
  localparam logic [7:0] ASC_0       = 8'h30;
  localparam logic [7:0] ASC_1       = 8'h31;
  localparam logic [7:0] ASC_2       = 8'h32;
  localparam logic [7:0] ASC_3       = 8'h33;
  localparam logic [7:0] ASC_4       = 8'h34;
  localparam logic [7:0] ASC_5       = 8'h35;
  localparam logic [7:0] ASC_6       = 8'h36;
  localparam logic [7:0] ASC_7       = 8'h37;
  localparam logic [7:0] ASC_8       = 8'h38;
  localparam logic [7:0] ASC_9       = 8'h39;
  localparam logic [7:0] ASC_UA      = 8'h41;
  localparam logic [7:0] ASC_UB      = 8'h42;
  localparam logic [7:0] ASC_UC      = 8'h43;
  localparam logic [7:0] ASC_UD      = 8'h44;
  localparam logic [7:0] ASC_UF      = 8'h46;
  localparam logic [7:0] ASC_UH      = 8'h48;
  localparam logic [7:0] ASC_UO      = 8'h4f;
  localparam logic [7:0] ASC_UP      = 8'h50;
  localparam logic [7:0] ASC_UQ      = 8'h51;
  localparam logic [7:0] ASC_UR      = 8'h52;
  localparam logic [7:0] ASC_US      = 8'h53;
  localparam logic [7:0] ASC_LBRACK  = 8'h5b;
  localparam logic [7:0] ASC_LOWER_A = 8'h61;
  localparam logic [7:0] ASC_LOWER_Z = 8'h7a;
  localparam logic [7:0] ASC_TILDE   = 8'h7e;

  // Unshifted US layout for keycodes below caps lock, padded to 64
  localparam logic [7:0] PLAIN_TAB [64] = '{
    8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h7f, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
    8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h00,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Shifted US layout, same indexing
  localparam logic [7:0] SHIFT_TAB [64] = '{
    8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
    8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h7f, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
    8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h00,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Results of one event: bytes[0] goes out first
  typedef struct packed {
    logic            kind;
    logic [2:0]      count;
    logic [4:0][7:0] bytes;
  } kvt_job_t;

  // Memory access strobes from the event stage
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } kvt_mem_req_t;

  function automatic kvt_job_t kvt_seq(input logic [2:0] n, input logic [7:0] b0,
                                       input logic [7:0] b1, input logic [7:0] b2,
                                       input logic [7:0] b3, input logic [7:0] b4);
    kvt_job_t j;
    j.kind  = KIND_BYTE;
    j.count = n;
    j.bytes = {b4, b3, b2, b1, b0};
    return j;
  endfunction

  // Map one accepted press to its result bytes
  function automatic kvt_job_t kvt_encode(input logic [9:0] code, input logic shift,
                                          input logic ctrl, input logic alt,
                                          input logic caps, input logic newline,
                                          input logic cursor_app);
    kvt_job_t   j;
    logic [7:0] c;
    logic [7:0] s;
    logic [7:0] lead;
    j    = kvt_seq(3'd0, ASC_NUL, ASC_NUL, ASC_NUL, ASC_NUL, ASC_NUL);
    c    = PLAIN_TAB[code[5:0]];
    s    = SHIFT_TAB[code[5:0]];
    lead = cursor_app ? ASC_UO : ASC_LBRACK;
    if (ctrl && code == KC_F3) begin
      j.kind  = KIND_SETUP;
      j.count = 3'd1;
    end else if (code < KC_TAB_LIMIT) begin
      if (c inside {[ASC_LOWER_A:ASC_LOWER_Z]}) begin
        if (ctrl) begin
          j = kvt_seq(3'd1, c & ASC_CTRL, ASC_NUL, ASC_NUL, ASC_NUL, ASC_NUL);
        end else begin
          if (shift ^ caps) c = c - ASC_CASE;
          j = alt ? kvt_seq(3'd2, ASC_ESC, c, ASC_NUL, ASC_NUL, ASC_NUL)
                  : kvt_seq(3'd1, c, ASC_NUL, ASC_NUL, ASC_NUL, ASC_NUL);
        end
      end else if (code inside {[KC_DIG_FIRST:KC_DIG_LAST]}) begin
        c = shift ? s : c;
        j = alt ? kvt_seq(3'd2, ASC_ESC, c, ASC_NUL, ASC_NUL, ASC_NUL)
                : kvt_seq(3'd1, c, ASC_NUL, ASC_NUL, ASC_NUL, ASC_NUL);
      end else if (code == KC_ENTER) begin
        j = newline ? kvt_seq(3'd2, ASC_CR, ASC_LF, ASC_NUL, ASC_NUL, ASC_NUL)
                    : kvt_seq(3'd1, ASC_CR, ASC_NUL, ASC_NUL, ASC_NUL, ASC_NUL);
      end else if (c != ASC_NUL) begin
        j = kvt_seq(3'd1, shift ? s : c, ASC_NUL, ASC_NUL, ASC_NUL, ASC_NUL);
      end
    end else begin
      case (code)
        KC_RIGHT:  j = kvt_seq(3'd3, ASC_ESC, lead, ASC_UC, ASC_NUL, ASC_NUL);
        KC_LEFT:   j = kvt_seq(3'd3, ASC_ESC, lead, ASC_UD, ASC_NUL, ASC_NUL);
        KC_DOWN:   j = kvt_seq(3'd3, ASC_ESC, lead, ASC_UB, ASC_NUL, ASC_NUL);
        KC_UP:     j = kvt_seq(3'd3, ASC_ESC, lead, ASC_UA, ASC_NUL, ASC_NUL);
        KC_INSERT: j = kvt_seq(3'd4, ASC_ESC, ASC_LBRACK, ASC_2, ASC_TILDE, ASC_NUL);
        KC_HOME:   j = kvt_seq(3'd3, ASC_ESC, ASC_LBRACK, ASC_UH, ASC_NUL, ASC_NUL);
        KC_PGUP:   j = kvt_seq(3'd4, ASC_ESC, ASC_LBRACK, ASC_5, ASC_TILDE, ASC_NUL);
        KC_DELETE: j = kvt_seq(3'd4, ASC_ESC, ASC_LBRACK, ASC_3, ASC_TILDE, ASC_NUL);
        KC_END:    j = kvt_seq(3'd3, ASC_ESC, ASC_LBRACK, ASC_UF, ASC_NUL, ASC_NUL);
        KC_PGDN:   j = kvt_seq(3'd4, ASC_ESC, ASC_LBRACK, ASC_6, ASC_TILDE, ASC_NUL);
        KC_F1:     j = kvt_seq(3'd3, ASC_ESC, ASC_UO, ASC_UP, ASC_NUL, ASC_NUL);
        KC_F2:     j = kvt_seq(3'd3, ASC_ESC, ASC_UO, ASC_UQ, ASC_NUL, ASC_NUL);
        KC_F3:     j = kvt_seq(3'd3, ASC_ESC, ASC_UO, ASC_UR, ASC_NUL, ASC_NUL);
        KC_F4:     j = kvt_seq(3'd3, ASC_ESC, ASC_UO, ASC_US, ASC_NUL, ASC_NUL);
        KC_F5:     j = kvt_seq(3'd5, ASC_ESC, ASC_LBRACK, ASC_1, ASC_5, ASC_TILDE);
        KC_F6:     j = kvt_seq(3'd5, ASC_ESC, ASC_LBRACK, ASC_1, ASC_7, ASC_TILDE);
        KC_F7:     j = kvt_seq(3'd5, ASC_ESC, ASC_LBRACK, ASC_1, ASC_8, ASC_TILDE);
        KC_F8:     j = kvt_seq(3'd5, ASC_ESC, ASC_LBRACK, ASC_1, ASC_9, ASC_TILDE);
        KC_F9:     j = kvt_seq(3'd5, ASC_ESC, ASC_LBRACK, ASC_2, ASC_0, ASC_TILDE);
        KC_F10:    j = kvt_seq(3'd5, ASC_ESC, ASC_LBRACK, ASC_2, ASC_1, ASC_TILDE);
        KC_F11:    j = kvt_seq(3'd5, ASC_ESC, ASC_LBRACK, ASC_2, ASC_3, ASC_TILDE);
        KC_F12:    j = kvt_seq(3'd5, ASC_ESC, ASC_LBRACK, ASC_2, ASC_4, ASC_TILDE);
        default:   j.count = 3'd0;
      endcase
    end
    return j;
  endfunction

endpackage

`default_nettype wire

// File: rtl/kvt_key_mem.sv
`default_nettype none

module kvt_key_mem #(
  parameter int KEY_CODES  = 768,
  parameter int STAMP_BITS = 32,
  parameter int AW         = $clog2(KEY_CODES)
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire  kvt_pkg::kvt_mem_req_t       req,
  input  wire  [AW-1:0]                     rd_addr,
  input  wire  [AW-1:0]                     wr_addr,
  input  wire  [kvt_pkg::OWNER_BITS-1:0]    wr_owner,
  input  wire  [STAMP_BITS-1:0]             wr_stamp,
  output logic [kvt_pkg::OWNER_BITS-1:0]    rd_owner,
  output logic [STAMP_BITS-1:0]             rd_stamp,
  output logic                              clearing
);
  import kvt_pkg::*;

  localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_CODES - 1);

  logic [OWNER_BITS-1:0] owner_mem [KEY_CODES];
  logic [STAMP_BITS-1:0] stamp_mem [KEY_CODES];
  logic [AW-1:0]         clr_addr;

  // Sweep the owner table to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) clearing <= 1'b0;
      else clr_addr <= clr_addr + 1'b1;
    end
  end

  // Owner table: clear port shares the write port
  always_ff @(posedge clk) begin
    if (clearing) owner_mem[clr_addr] <= '0;
    else if (req.wr_en) owner_mem[wr_addr] <= wr_owner;
    if (req.rd_en) rd_owner <= owner_mem[rd_addr];
  end

  // Stamp table: written with the owner, never cleared
  always_ff @(posedge clk) begin
    if (req.wr_en) stamp_mem[wr_addr] <= wr_stamp;
    if (req.rd_en) rd_stamp <= stamp_mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/kvt_event_stage.sv
`default_nettype none

module kvt_event_stage #(
  parameter int KEY_CODES  = 768,
  parameter int NODE_COUNT = 8,
  parameter int STAMP_BITS = 32,
  parameter int AW         = $clog2(KEY_CODES)
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               cmd,
  input  wire  [4:0]                        event_type,
  input  wire  [9:0]                        keycode,
  input  wire  [1:0]                        key_value,
  input  wire  [2:0]                        source_node,
  input  wire  [31:0]                       timestamp_ms,
  input  wire  [7:0]                        dup_window,
  input  wire                               newline_mode,
  input  wire                               cursor_app_mode,
  input  wire                               clearing,
  output kvt_pkg::kvt_mem_req_t             mem_req,
  output logic [AW-1:0]                     rd_addr,
  output logic [AW-1:0]                     wr_addr,
  output logic [kvt_pkg::OWNER_BITS-1:0]    wr_owner,
  output logic [STAMP_BITS-1:0]             wr_stamp,
  input  wire  [kvt_pkg::OWNER_BITS-1:0]    rd_owner,
  input  wire  [STAMP_BITS-1:0]             rd_stamp,
  output logic                              job_valid,
  input  wire                               job_ready,
  output kvt_pkg::kvt_job_t                 job
);
  import kvt_pkg::*;

  localparam logic [10:0] CODE_LIMIT = 11'(KEY_CODES);
  localparam logic [3:0]  NODE_LIMIT = 4'(NODE_COUNT);

  // Stage registers
  logic                  s1_valid;
  logic                  s1_cmd;
  logic [4:0]            s1_type;
  logic [9:0]            s1_code;
  logic [1:0]            s1_value;
  logic [2:0]            s1_source;
  logic [STAMP_BITS-1:0] s1_stamp;

  // Key state
  logic shift_held, ctrl_held, alt_held, caps_on;

  // Last table write, for a read issued at the same edge
  logic                  fwd_valid;
  logic [AW-1:0]         fwd_addr;
  logic [OWNER_BITS-1:0] fwd_owner;
  logic [STAMP_BITS-1:0] fwd_stamp;

  logic                  accept;
  logic                  advance;
  logic [AW-1:0]         s1_addr;
  logic                  fwd_hit;
  logic [OWNER_BITS-1:0] cur_owner;
  logic [STAMP_BITS-1:0] cur_stamp;
  logic [STAMP_BITS-1:0] stamp_diff;
  logic [OWNER_BITS-1:0] my_id;
  logic                  src_ok;
  logic                  is_key;
  logic                  is_shift, is_ctrl, is_alt, is_mod;
  logic                  is_press;
  logic                  in_range;
  logic                  is_dup;
  logic                  emit;
  logic                  held;

  // Handshake and table read
  assign advance = s1_valid && job_ready;
  assign in_ready = !clearing && (!s1_valid || advance);
  assign accept = in_valid && in_ready;
  assign rd_addr = keycode[AW-1:0];

  // Decide on the request in the stage
  always_comb begin
    s1_addr    = s1_code[AW-1:0];
    fwd_hit    = fwd_valid && (fwd_addr == s1_addr);
    cur_owner  = fwd_hit ? fwd_owner : rd_owner;
    cur_stamp  = fwd_hit ? fwd_stamp : rd_stamp;
    stamp_diff = s1_stamp - cur_stamp;
    my_id      = {1'b0, s1_source} + 4'd1;
    src_ok     = {1'b0, s1_source} < NODE_LIMIT;
    is_key     = (s1_cmd == CMD_KEY) && (s1_type == EV_KEY) && src_ok;
    is_shift   = (s1_code == KC_LSHIFT) || (s1_code == KC_RSHIFT);
    is_ctrl    = (s1_code == KC_LCTRL) || (s1_code == KC_RCTRL);
    is_alt     = (s1_code == KC_LALT) || (s1_code == KC_RALT);
    is_mod     = is_shift || is_ctrl || is_alt;
    is_press   = (s1_value == KV_PRESS) || (s1_value == KV_REPEAT);
    held       = s1_value != KV_RELEASE;
    in_range   = {1'b0, s1_code} < CODE_LIMIT;
    is_dup     = in_range && (cur_owner != '0) && (cur_owner != my_id) &&
                 (stamp_diff < STAMP_BITS'(dup_window));
    emit       = is_key && !is_mod && is_press && !is_dup;
    job        = kvt_encode(s1_code, shift_held, ctrl_held, alt_held, caps_on,
                            newline_mode, cursor_app_mode);
    job_valid  = s1_valid && emit && (job.count != 3'd0);
    mem_req.rd_en = accept;
    mem_req.wr_en = advance && emit && in_range;
    wr_addr    = s1_addr;
    wr_owner   = my_id;
    wr_stamp   = s1_stamp;
  end

  // Hold or refill the stage
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (accept) s1_valid <= 1'b1;
    else if (advance) s1_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd    <= cmd;
      s1_type   <= event_type;
      s1_code   <= keycode;
      s1_value  <= key_value;
      s1_source <= source_node;
      s1_stamp  <= STAMP_BITS'(timestamp_ms);
    end
  end

  // Update modifiers and caps lock as requests leave the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      ctrl_held  <= 1'b0;
      alt_held   <= 1'b0;
      caps_on    <= 1'b0;
    end else if (advance) begin
      if (s1_cmd == CMD_LOST) begin
        shift_held <= 1'b0;
        ctrl_held  <= 1'b0;
        alt_held   <= 1'b0;
      end else if (is_key) begin
        if (is_shift) shift_held <= held;
        if (is_ctrl) ctrl_held <= held;
        if (is_alt) alt_held <= held;
      end
      if (emit && s1_code == KC_CAPS) caps_on <= !caps_on;
    end
  end

  // Track the latest table write
  always_ff @(posedge clk) begin
    if (rst) fwd_valid <= 1'b0;
    else if (mem_req.wr_en) fwd_valid <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      fwd_addr  <= s1_addr;
      fwd_owner <= my_id;
      fwd_stamp <= s1_stamp;
    end
  end

endmodule

`default_nettype wire

// File: rtl/kvt_byte_ser.sv
`default_nettype none

module kvt_byte_ser (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  job_valid,
  output logic                 job_ready,
  input  wire kvt_pkg::kvt_job_t job,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 out_kind,
  output logic [7:0]           out_byte,
  output logic                 last
);
  import kvt_pkg::*;

  logic            busy;
  logic            kind;
  logic [2:0]      rem;
  logic [4:0][7:0] bytes;
  logic            load;
  logic            done;

  assign last      = rem == 3'd1;
  assign done      = busy && out_ready && last;
  assign job_ready = !busy || (out_ready && last);
  assign load      = job_valid && job_ready;
  assign out_valid = busy;
  assign out_kind  = kind;
  assign out_byte  = bytes[0];

  // Track whether a request is being sent
  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b0;
    else if (load) busy <= 1'b1;
    else if (done) busy <= 1'b0;
  end

  // Load a new request or advance to its next byte
  always_ff @(posedge clk) begin
    if (load) begin
      kind  <= job.kind;
      rem   <= job.count;
      bytes <= job.bytes;
    end else if (busy && out_ready) begin
      rem   <= rem - 3'd1;
      bytes <= bytes >> 8;
    end
  end

endmodule

`default_nettype wire

// File: rtl/keycode_to_vt100_byte_encoder_unit.sv
// An event is registered in the event stage; the byte serializer loads it and offers
// its first result. An event enters each cycle the byte serializer can take it; an
// event with n results, five at most, holds the single output port until its last byte
// is taken, and the next event loads as that byte goes. The owner table gives one read
// and one write per cycle. Reset clears modifiers and configuration at once, then sweeps
// the owner table with in_ready low; configuration writes are taken once reset falls.
`default_nettype none

module keycode_to_vt100_byte_encoder_unit #(
  parameter int KEY_CODES  = 768,
  parameter int NODE_COUNT = 8,
  parameter int STAMP_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         cmd,
  input  wire  [4:0]  event_type,
  input  wire  [9:0]  keycode,
  input  wire  [1:0]  key_value,
  input  wire  [2:0]  source_node,
  input  wire  [31:0] timestamp_ms,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);
  import kvt_pkg::*;

  localparam int AW = $clog2(KEY_CODES);

  logic [7:0]            dup_window;
  logic                  newline_mode;
  logic                  cursor_app_mode;
  logic                  clearing;
  kvt_mem_req_t          mem_req;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [OWNER_BITS-1:0] wr_owner;
  logic [STAMP_BITS-1:0] wr_stamp;
  logic [OWNER_BITS-1:0] rd_owner;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic                  job_valid;
  logic                  job_ready;
  kvt_job_t              job;

  assign cfg_ready = !rst;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dup_window      <= DUP_WINDOW_RESET;
      newline_mode    <= 1'b0;
      cursor_app_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DUP_WINDOW: dup_window      <= cfg_data;
        CFG_NEWLINE:    newline_mode    <= cfg_data[0];
        CFG_CURSOR_APP: cursor_app_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  kvt_key_mem #(
    .KEY_CODES  (KEY_CODES),
    .STAMP_BITS (STAMP_BITS),
    .AW         (AW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (mem_req),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_owner (wr_owner),
    .wr_stamp (wr_stamp),
    .rd_owner (rd_owner),
    .rd_stamp (rd_stamp),
    .clearing (clearing)
  );

  kvt_event_stage #(
    .KEY_CODES  (KEY_CODES),
    .NODE_COUNT (NODE_COUNT),
    .STAMP_BITS (STAMP_BITS),
    .AW         (AW)
  ) u_stage (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .event_type      (event_type),
    .keycode         (keycode),
    .key_value       (key_value),
    .source_node     (source_node),
    .timestamp_ms    (timestamp_ms),
    .dup_window      (dup_window),
    .newline_mode    (newline_mode),
    .cursor_app_mode (cursor_app_mode),
    .clearing        (clearing),
    .mem_req         (mem_req),
    .rd_addr         (rd_addr),
    .wr_addr         (wr_addr),
    .wr_owner        (wr_owner),
    .wr_stamp        (wr_stamp),
    .rd_owner        (rd_owner),
    .rd_stamp        (rd_stamp),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .job             (job)
  );

  kvt_byte_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

`default_nettype wire

// File: rtl/kvt_checker.sv
`default_nettype none
`include "keycode_to_vt100_byte_encoder_unit_assert.svh"

module kvt_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       out_kind,
  input wire [7:0] out_byte,
  input wire       last
);
  import kvt_pkg::*;

  // A stalled result holds
  `KVT_CHECK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind) && $stable(last))

  // A setup request stands alone and carries no byte
  `KVT_CHECK(a_setup_alone, clk, rst, out_valid && out_kind == KIND_SETUP |-> last && out_byte == 8'h00)

  // The bytes of one request go out without a gap
  `KVT_CHECK(a_seq_no_gap, clk, rst, out_valid && out_ready && !last |=> out_valid)

  // Reset starts the owner sweep and empties the output
  `KVT_CHECK_ALWAYS(a_rst_sweep, clk, rst |=> !in_ready)
  `KVT_CHECK_ALWAYS(a_rst_empty, clk, rst |=> !out_valid)

endmodule

bind keycode_to_vt100_byte_encoder_unit kvt_checker u_kvt_checker (.*);

`default_nettype wire
